/* src/mfdc_pkg.sv */
// Shared types, constants and helper functions for the modulated feedback delay chorus.
package mfdc_pkg;

    // Field and register widths
    localparam int AUDIO_W    = 24;
    localparam int MOD_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int BASE_W     = 20;
    localparam int FB_W       = 16;
    localparam int WET_W      = 17;
    localparam int SR_W       = 18;
    localparam int COEF_W     = 17;
    localparam int SMOOTH_W   = 32;
    localparam int DIFF_W     = 34;
    localparam int FRAC_W     = 16;

    // Shared multiplier: signed A x signed B
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    // Delay in Q.16 samples after dropping 14 bits of the time x rate product
    localparam int DQ_W    = PROD_W - 14;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH     = 3'd4;

    // Register reset values
    localparam logic [SR_W-1:0]   RATE_RESET   = 18'd48000;
    localparam logic [COEF_W-1:0] SMOOTH_RESET = 17'd1311;

    // Arithmetic constants
    localparam logic signed [MUL_B_W-1:0] MOD_SCALE = 25'sd8589935; // 0.002 s in 2^-32 s
    localparam logic [FB_W-1:0]           FB_MAX    = 16'd64225;    // 0.98 in Q0.16
    localparam logic [WET_W-1:0]          UNITY     = 17'd65536;
    localparam logic signed [AUDIO_W-1:0] S24_MAX   = 24'sh7FFFFF;
    localparam logic signed [AUDIO_W-1:0] S24_MIN   = 24'sh800000;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_MOD,
        S_TARGET,
        S_MUL_SMOOTH,
        S_SMOOTH,
        S_MUL_RATE,
        S_POS,
        S_RD0,
        S_RD1,
        S_Y1,
        S_WRITE,
        S_MUL_INTERP,
        S_INTERP,
        S_MUL_DRY,
        S_MUL_WET,
        S_MIX
    } t_state;

    // Round half up, then arithmetic shift right by s
    function automatic logic signed [PROD_W-1:0] rnd_shr(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              s
    );
        logic signed [PROD_W-1:0] half;
        half    = signed'(PROD_W'(1) << (s - 1));
        rnd_shr = (v + half) >>> s;
    endfunction

    // Saturate to signed 24 bits
    function automatic logic signed [AUDIO_W-1:0] sat24(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(S24_MAX);
        lo = PROD_W'(S24_MIN);
        if (v > hi) begin
            sat24 = S24_MAX;
        end else if (v < lo) begin
            sat24 = S24_MIN;
        end else begin
            sat24 = v[AUDIO_W-1:0];
        end
    endfunction

endpackage

/* src/mfdc_in_if.sv */
// Input item channel: audio sample and modulation sample.
interface mfdc_in_if
    import mfdc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [AUDIO_W-1:0] audio_in;
    logic signed [MOD_W-1:0]   modulation;

    modport source (output valid, output audio_in, output modulation, input ready);
    modport sink   (input valid, input audio_in, input modulation, output ready);
endinterface

/* src/mfdc_out_if.sv */
// Result item channel: mixed output sample.
interface mfdc_out_if
    import mfdc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [AUDIO_W-1:0] audio_out;

    modport source (output valid, output audio_out, input ready);
    modport sink   (input valid, input audio_out, output ready);
endinterface

/* src/mfdc_cfg_if.sv */
// Configuration write channel: register index and write data.
interface mfdc_cfg_if
    import mfdc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/mfdc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mfdc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/modulated_feedback_delay_chorus.sv */
// Modulated feedback delay (chorus) with linearly interpolated read, top level.
// The single shared multiplier and the one read port of the delay RAM are visited in turn
// by the sequencer, which takes a new item only in S_IDLE and holds in S_MIX while the
// output register is full and not taken. Reset (i_rst_n low, synchronous) clears the
// sequencer, smoother, feedback sample, write pointer and output valid and loads the
// register reset values; delay RAM entries not written since reset read as zero.
module modulated_feedback_delay_chorus
    import mfdc_pkg::*;
#(
    parameter int STORE_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfdc_in_if.sink     i_in,
    mfdc_out_if.source  o_out,
    mfdc_cfg_if.sink    i_cfg
);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int IW = AW + 1;
    localparam int PW = IW + FRAC_W;
    localparam logic [DQ_W-1:0] DMAX      = DQ_W'(STORE_DEPTH - 1) << FRAC_W;
    localparam logic [PW-1:0]   DEPTH_FIX = {IW'(STORE_DEPTH), {FRAC_W{1'b0}}};
    localparam logic [AW-1:0]   LAST_IDX  = AW'(STORE_DEPTH - 1);

    // Control and state registers
    t_state                     r_state, n_state;
    logic                       r_out_valid;
    logic [AW-1:0]              r_wp;
    logic                       r_filled;
    logic signed [SMOOTH_W-1:0] r_smoothed;
    logic signed [AUDIO_W-1:0]  r_last;

    // Configuration registers
    logic [BASE_W-1:0] r_base;
    logic [FB_W-1:0]   r_fb;
    logic [WET_W-1:0]  r_wet;
    logic [SR_W-1:0]   r_sr;
    logic [COEF_W-1:0] r_coef;

    // Payload registers
    logic signed [AUDIO_W-1:0] r_x;
    logic signed [MOD_W-1:0]   r_mod;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_acc;
    logic [AW-1:0]             r_i0;
    logic [FRAC_W-1:0]         r_t;
    logic                      r_v0, r_v1;
    logic signed [AUDIO_W-1:0] r_y0, r_y1;
    logic signed [AUDIO_W-1:0] r_out_data;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic                      mul_en;

    // RAM port
    logic                ram_we;
    logic [AW-1:0]       ram_raddr;
    logic [AUDIO_W-1:0]  ram_rdata;
    logic                raddr_valid;

    // Datapath helpers
    logic [COEF_W-1:0]          coef;
    logic [FB_W-1:0]            fb;
    logic [WET_W-1:0]           wet;
    logic [WET_W-1:0]           dry;
    logic signed [DIFF_W-1:0]   target;
    logic signed [SMOOTH_W-1:0] smoothed_new;
    logic [DQ_W-1:0]            dq_raw, dq;
    logic [PW-1:0]              pos_base, pos_raw, pos;
    logic [AW-1:0]              i1;
    logic [AW-1:0]              wp_next;
    logic signed [AUDIO_W-1:0]  wr_sample;
    logic signed [AUDIO_W-1:0]  rd_sample;
    logic signed [AUDIO_W-1:0]  mix_sample;
    logic                       out_free;

    // Clamped gains
    always_comb begin
        coef = r_coef[COEF_W-1] ? UNITY : r_coef;
        wet  = r_wet[WET_W-1] ? UNITY : r_wet;
        fb   = (r_fb > FB_MAX) ? FB_MAX : r_fb;
        dry  = UNITY - wet;
    end

    // Smoother target and update
    always_comb begin
        target       = signed'({4'b0000, r_base, 10'b0000000000})
                       + DIFF_W'(rnd_shr(r_prod, 17));
        smoothed_new = r_smoothed - SMOOTH_W'(rnd_shr(r_prod, 16));
    end

    // Read position: newest sample minus the clamped fractional delay
    always_comb begin
        dq_raw   = r_prod[PROD_W-1:14];
        dq       = (dq_raw > DMAX) ? DMAX : dq_raw;
        pos_base = {IW'(r_wp) + IW'(STORE_DEPTH - 1), {FRAC_W{1'b0}}};
        pos_raw  = pos_base - PW'(dq);
        pos      = (pos_raw >= DEPTH_FIX) ? pos_raw - DEPTH_FIX : pos_raw;
    end

    // Index wraps
    assign i1      = (r_i0 == LAST_IDX) ? '0 : r_i0 + 1'b1;
    assign wp_next = (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;

    // Sample arithmetic on the registered product
    always_comb begin
        wr_sample  = sat24(PROD_W'(r_x) + rnd_shr(r_prod, 16));
        rd_sample  = sat24(PROD_W'(r_y0) + rnd_shr(r_prod, 16));
        mix_sample = sat24(rnd_shr(r_acc + r_prod, 16));
    end

    assign out_free = !r_out_valid || o_out.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:       if (i_in.valid) n_state = S_MUL_MOD;
            S_MUL_MOD:    n_state = S_TARGET;
            S_TARGET:     n_state = S_MUL_SMOOTH;
            S_MUL_SMOOTH: n_state = S_SMOOTH;
            S_SMOOTH:     n_state = S_MUL_RATE;
            S_MUL_RATE:   n_state = S_POS;
            S_POS:        n_state = S_RD0;
            S_RD0:        n_state = S_RD1;
            S_RD1:        n_state = S_Y1;
            S_Y1:         n_state = S_WRITE;
            S_WRITE:      n_state = S_MUL_INTERP;
            S_MUL_INTERP: n_state = S_INTERP;
            S_INTERP:     n_state = S_MUL_DRY;
            S_MUL_DRY:    n_state = S_MUL_WET;
            S_MUL_WET:    n_state = S_MIX;
            S_MIX:        if (out_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands and RAM controls
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mul_en    = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = i1;
        case (r_state)
            S_MUL_MOD: begin
                mul_a  = MUL_A_W'(r_mod);
                mul_b  = MOD_SCALE;
                mul_en = 1'b1;
            end
            S_MUL_SMOOTH: begin
                mul_a  = MUL_A_W'(r_diff);
                mul_b  = signed'(MUL_B_W'(coef));
                mul_en = 1'b1;
            end
            S_MUL_RATE: begin
                mul_a  = (r_smoothed > 32'sd0) ? MUL_A_W'(r_smoothed) : '0;
                mul_b  = signed'(MUL_B_W'(r_sr));
                mul_en = 1'b1;
            end
            S_RD0: begin
                ram_raddr = r_i0;
            end
            S_Y1: begin
                mul_a  = MUL_A_W'(r_last);
                mul_b  = signed'(MUL_B_W'(fb));
                mul_en = 1'b1;
            end
            S_WRITE: begin
                ram_we = 1'b1;
            end
            S_MUL_INTERP: begin
                mul_a  = MUL_A_W'(r_y1) - MUL_A_W'(r_y0);
                mul_b  = signed'(MUL_B_W'(r_t));
                mul_en = 1'b1;
            end
            S_MUL_DRY: begin
                mul_a  = MUL_A_W'(r_x);
                mul_b  = signed'(MUL_B_W'(dry));
                mul_en = 1'b1;
            end
            S_MUL_WET: begin
                mul_a  = MUL_A_W'(r_last);
                mul_b  = signed'(MUL_B_W'(wet));
                mul_en = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Entries not yet written since reset read as zero
    assign raddr_valid = r_filled || (ram_raddr < r_wp);

    // Control state, model state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wp        <= '0;
            r_filled    <= 1'b0;
            r_smoothed  <= '0;
            r_last      <= '0;
            r_base      <= '0;
            r_fb        <= '0;
            r_wet       <= '0;
            r_sr        <= RATE_RESET;
            r_coef      <= SMOOTH_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == S_SMOOTH) begin
                r_smoothed <= smoothed_new;
            end
            if (r_state == S_WRITE) begin
                r_wp <= wp_next;
                if (r_wp == LAST_IDX) r_filled <= 1'b1;
            end
            if (r_state == S_INTERP) begin
                r_last <= rd_sample;
            end
            // Output register
            if (r_state == S_MIX && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            // Configuration writes; unknown indexes are ignored
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_BASE_DELAY: r_base <= i_cfg.data[BASE_W-1:0];
                    REG_FEEDBACK:   r_fb   <= i_cfg.data[FB_W-1:0];
                    REG_WET:        r_wet  <= i_cfg.data[WET_W-1:0];
                    REG_RATE:       r_sr   <= i_cfg.data[SR_W-1:0];
                    REG_SMOOTH:     r_coef <= i_cfg.data[COEF_W-1:0];
                    default:        r_base <= r_base;
                endcase
            end
        end
    end

    // Datapath payload
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
        case (r_state)
            S_IDLE: begin
                r_x   <= i_in.audio_in;
                r_mod <= i_in.modulation;
            end
            S_TARGET: begin
                r_diff <= DIFF_W'(r_smoothed) - target;
            end
            S_POS: begin
                r_i0 <= pos[AW+FRAC_W-1:FRAC_W];
                r_t  <= pos[FRAC_W-1:0];
            end
            S_RD0: begin
                r_v0 <= raddr_valid;
            end
            S_RD1: begin
                r_v1 <= raddr_valid;
                r_y0 <= r_v0 ? signed'(ram_rdata) : '0;
            end
            S_Y1: begin
                r_y1 <= r_v1 ? signed'(ram_rdata) : '0;
            end
            S_MUL_WET: begin
                r_acc <= r_prod;
            end
            S_MIX: begin
                if (out_free) r_out_data <= mix_sample;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // Delay store
    mfdc_ram #(
        .WIDTH (AUDIO_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (wr_sample),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Port drive
    assign i_in.ready      = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.audio_out = r_out_data;

endmodule

/* src/mfdc_checker.sv */
// Port-level checker for the chorus top level, with its bind.
module mfdc_checker
    import mfdc_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic signed [AUDIO_W-1:0] i_out_audio
);
    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A waiting result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_audio))
        else $error("stalled result changed");

    // The block only goes busy on an accepted item
    a_busy_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_in_valid && i_in_ready))
        else $error("input side went busy without an accepted item");

    // A new result comes out just as the block frees up for the next item
    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("result presented while still busy");
endmodule

bind modulated_feedback_delay_chorus mfdc_checker u_mfdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_audio (o_out.audio_out)
);
